[hw/rtl/twsac_pkg.sv]
// Shared types and constants for the two-way set-associative cache tag unit.
// Used by the modulo unit, the tag RAM user, the top level and the checker.
`default_nettype none

package twsac_pkg;

  localparam int ADDR_W           = 16;
  localparam int CFG_W            = 11;
  localparam int SET_OUT_W        = 10;
  localparam int IN_TDATA_W       = 16;
  localparam int OUT_TDATA_W      = 32;
  localparam int STEP_W           = $clog2(ADDR_W + 1);
  localparam int DEF_MAX_SETS     = 1024;
  localparam int DEF_ADDRESS_BITS = 16;
  localparam logic [CFG_W-1:0] NUM_SETS_RESET = CFG_W'(2);
  localparam logic [CFG_W-1:0] MIN_SETS       = CFG_W'(2);

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  typedef struct packed {
    logic              recent_zero;
    logic              valid_one;
    logic              valid_zero;
    logic [ADDR_W-1:0] tag_one;
    logic [ADDR_W-1:0] tag_zero;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

`default_nettype wire

[hw/rtl/twsac_mod_unit.sv]
// Iterative restoring modulo unit: one remainder bit per cycle.
// Depends on twsac_pkg for widths and the status struct.
`default_nettype none

module twsac_mod_unit import twsac_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] dividend,
  input  wire logic [CFG_W-1:0]  divisor,
  output mod_stat_t              stat,
  output logic [CFG_W-1:0]       remainder
);

  logic [ADDR_W-1:0] quo_sh;
  logic [STEP_W-1:0] count;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;

  assign trial = {remainder, quo_sh[ADDR_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      count     <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        count     <= STEP_W'(ADDR_W);
      end else if (stat.busy) begin
        count <= count - STEP_W'(1);
        if (count == STEP_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh    <= dividend;
      remainder <= '0;
    end else if (stat.busy) begin
      quo_sh    <= quo_sh << 1;
      remainder <= (trial >= {1'b0, divisor}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/twsac_tag_ram.sv]
// Single-port-write, registered-read RAM holding one tag row per set.
// Depends on twsac_pkg for its default depth and row width.
`default_nettype none

module twsac_tag_ram import twsac_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_SETS,
  parameter int IDX_W  = $clog2(DEF_MAX_SETS),
  parameter int DATA_W = ROW_W
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0]      rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/two_way_set_assoc_cache_lru_unit.sv]
// Top level of the two-way set-associative cache tag unit with LRU replacement.
// Depends on twsac_pkg, twsac_mod_unit and twsac_tag_ram.
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata[15:0] block_address
//  m_axis    out        m_axis_tvalid/tready    tdata: hit, set_index, way,
//                                               evicted_valid, evicted_block
//  cfg       in         cfg_valid/cfg_ready     cfg_data[10:0] num_sets
//
// An item passes from acceptance to result through 16 modulo steps in the
// restoring unit, a tag RAM read and the lookup/write-back.
// After reset a clearing pass writes every set with s_axis not ready; cfg
// writes are taken throughout. A stalled result holds the lookup cycle until
// the output register frees, one item in flight at a time.
`default_nettype none

module two_way_set_assoc_cache_lru_unit import twsac_pkg::*; #(
  parameter int MAX_SETS     = DEF_MAX_SETS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [15:0] block_address
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] hit, [10:1] set_index, [11] way, [12] evicted_valid,
  // [28:13] evicted_block, [31:29] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int AB    = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK  = ADDR_W'((64'd1 << AB) - 64'd1);
  localparam logic [31:0]       MAX_SETS_U = 32'(MAX_SETS);
  localparam logic [SET_W-1:0]  LAST_SET   = SET_W'(MAX_SETS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [SET_W-1:0]  clr_idx;
  logic [CFG_W-1:0]  num_sets;
  logic [CFG_W-1:0]  eff_sets;
  logic [CFG_W-1:0]  div_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] addr_in;
  logic              in_accept;
  logic              out_load;

  mod_stat_t         mod_stat;
  logic [CFG_W-1:0]  remainder;
  logic [SET_W-1:0]  set_idx;

  row_t              rd_row;
  row_t              wr_row;
  logic              ram_we;
  logic [SET_W-1:0]  ram_waddr;
  logic [ROW_W-1:0]  ram_rdata;

  logic              hit0;
  logic              hit1;
  logic              hit;
  logic              way;
  logic              ev_valid;
  logic [ADDR_W-1:0] ev_block;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign addr_in       = s_axis_tdata[ADDR_W-1:0] & ADDR_MASK;
  assign set_idx       = SET_W'(remainder);

  always_comb begin
    if (num_sets < MIN_SETS) begin
      eff_sets = MIN_SETS;
    end else if (32'(num_sets) > MAX_SETS_U) begin
      eff_sets = CFG_W'(MAX_SETS_U);
    end else begin
      eff_sets = num_sets;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sets <= NUM_SETS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_sets <= cfg_data;
    end
  end

  twsac_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept),
    .dividend  (addr_in),
    .divisor   (div_q),
    .stat      (mod_stat),
    .remainder (remainder)
  );

  twsac_tag_ram #(
    .DEPTH  (MAX_SETS),
    .IDX_W  (SET_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_row),
    .raddr (set_idx),
    .rdata (ram_rdata)
  );

  assign rd_row = row_t'(ram_rdata);

  always_comb begin
    hit0 = rd_row.valid_zero && (rd_row.tag_zero == addr_q);
    hit1 = rd_row.valid_one && (rd_row.tag_one == addr_q);
    hit  = hit0 || hit1;
    if (hit0) begin
      way = 1'b0;
    end else if (hit1) begin
      way = 1'b1;
    end else begin
      way = rd_row.valid_zero && rd_row.recent_zero;
    end
    ev_valid = !hit && (way ? rd_row.valid_one : rd_row.valid_zero);
    ev_block = ev_valid ? (way ? rd_row.tag_one : rd_row.tag_zero) : '0;
  end

  assign out_load = (state == ST_LOOK) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    wr_row = rd_row;
    if (state == ST_CLEAR) begin
      wr_row = '0;
    end else begin
      if (!hit) begin
        if (way) begin
          wr_row.tag_one   = addr_q;
          wr_row.valid_one = 1'b1;
        end else begin
          wr_row.tag_zero   = addr_q;
          wr_row.valid_zero = 1'b1;
        end
      end
      wr_row.recent_zero = !way;
    end
    ram_we    = (state == ST_CLEAR) || out_load;
    ram_waddr = (state == ST_CLEAR) ? clr_idx : set_idx;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_SET) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_stat.done) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_q <= addr_in;
      div_q  <= eff_sets;
    end
    if (out_load) begin
      m_axis_tdata <= {3'b000, ev_block, ev_valid, way, SET_OUT_W'(remainder), hit};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/twsac_checker.sv]
// Port-level checker for the cache tag unit, bound to the top level.
// Depends on twsac_pkg for port widths.
`default_nettype none

module twsac_checker import twsac_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("output valid or input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready again right after an accepted item");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[12] && (m_axis_tdata[28:13] == '0))
    else $error("hit reported an eviction");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[12] |-> (m_axis_tdata[28:13] == '0))
    else $error("evicted block nonzero without eviction");

endmodule

bind two_way_set_assoc_cache_lru_unit twsac_checker u_twsac_checker (.*);

`default_nettype wire
